[rtl/core/afrq_pkg.sv]
// afrq_pkg: request/result types, metadata entry type, function, status and
// state codes for the audio frame ring queue. No dependencies.
package afrq_pkg;

    // function codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CPOP  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_DELIVERED = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_TOO_NEW   = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // register map
    localparam logic [1:0] CAP_ADDR  = 2'd0;   // capacity, byte address 0
    localparam logic [3:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]          func;
        logic signed [15:0]  sample;
        logic                last_sample;
        logic signed [63:0]  stamp_in;
        logic [63:0]         header_in;
        logic signed [31:0]  frame_limit;
    } afrq_in_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [15:0]  sample_out;
        logic [6:0]          frame_length;
        logic signed [63:0]  stamp_out;
        logic [63:0]         header_out;
        logic                last_out;
        logic                truncated;
        logic [3:0]          occupancy;
    } afrq_out_t;

    typedef struct packed {
        logic [6:0]          len;
        logic signed [63:0]  stamp;
        logic [63:0]         header;
    } afrq_meta_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_STREAM
    } afrq_state_t;

endpackage

[rtl/core/audio_frame_ring_queue_core.sv]
// audio_frame_ring_queue_core: ring queue of audio frames, oldest frame
// overwritten when full. Depends on afrq_pkg.
//
// Usage: a request is taken when start is high and busy is low. A push
// (one sample per request) leaves busy low, so pushes can be issued every
// cycle while no pop is in progress; clear and a pop on an empty queue
// also leave busy low. A pop reads the frame's length/stamp/header entry
// synchronously, then streams its samples out of the sample memory (one
// read port, one sample per cycle); busy stays high until the last sample
// has been issued. A conditional pop that finds the head frame too new
// returns to idle after the entry read, streaming no samples. Every
// result appears on 'result' for exactly one cycle with 'strobe' high, in
// the cycle after the one that produced it; there is no backpressure, the
// receiver must take each result when strobe is high. A push without
// last_sample gives no result. The capacity register (byte address 0)
// sets the number of slots in use; write it only while the block is idle.
module audio_frame_ring_queue_core #(
    parameter int SLOTS         = 8,
    parameter int FRAME_SAMPLES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  afrq_pkg::afrq_in_t   req,
    // result channel
    output logic                 strobe,
    output afrq_pkg::afrq_out_t  result,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import afrq_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int EW    = (SW + 1 > 4) ? SW + 1 : 4;
    localparam int DEPTH = SLOTS * FRAME_SAMPLES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] FS7 = 7'(FRAME_SAMPLES);

    // ---------------------------------------------------------------
    // storage: sample memory and per-slot metadata memory
    // ---------------------------------------------------------------
    logic [15:0]  sample_mem [DEPTH];
    afrq_meta_t   meta_mem   [SLOTS];

    logic           sample_we, sample_re, meta_we, meta_re;
    logic [AW-1:0]  sample_waddr, sample_raddr;
    logic [15:0]    sample_wdata;
    logic [SW-1:0]  meta_waddr, meta_raddr;
    afrq_meta_t     meta_wdata;
    logic [15:0]    sample_rd_reg;
    afrq_meta_t     meta_rd_reg;

    // ---------------------------------------------------------------
    // control and payload registers
    // ---------------------------------------------------------------
    afrq_state_t    state_reg, state_next;
    logic [SW-1:0]  ws_reg, ws_next;
    logic [SW-1:0]  rs_reg, rs_next;
    logic [3:0]     count_reg, count_next;
    logic [6:0]     fill_reg, fill_next;
    logic           overrun_reg, overrun_next;
    logic [3:0]     cap_reg;
    logic [6:0]     idx_reg, idx_next;
    logic           strobe_reg, strobe_next;
    afrq_out_t      result_reg, result_next;
    logic [AW-1:0]  base_reg, base_next;
    logic           cond_reg, cond_next;
    logic signed [31:0] limit_reg, limit_next;

    logic           accept;
    logic           is_pop;
    logic [EW-1:0]  eff_cap;
    logic           full;
    logic [6:0]     head_len;
    logic           too_new;
    logic           stream_last;
    logic [AW-1:0]  rs_base;

    // next slot index, wraps at the effective capacity
    function automatic logic [SW-1:0] advance(input logic [SW-1:0] slot,
                                              input logic [EW-1:0] cap);
        logic [EW-1:0] nxt;
        nxt = EW'(slot) + EW'(1);
        if (nxt >= cap)
            return '0;
        return SW'(nxt);
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign is_pop = (req.func == FUNC_POP) || (req.func == FUNC_CPOP);

    // capacity 0 acts as 1, above SLOTS acts as SLOTS
    always_comb
    begin
        if (cap_reg == 4'd0)
            eff_cap = EW'(1);
        else if (EW'(cap_reg) > EW'(SLOTS))
            eff_cap = EW'(SLOTS);
        else
            eff_cap = EW'(cap_reg);
    end

    assign full     = (EW'(count_reg) >= eff_cap);
    assign rs_base  = AW'(AW'(rs_reg) * AW'(FRAME_SAMPLES));
    assign head_len = (meta_rd_reg.len > FS7) ? FS7 : meta_rd_reg.len;
    // signed compare of head stamp with the sign-extended limit
    assign too_new  = cond_reg &&
                      (meta_rd_reg.stamp > 64'(signed'(limit_reg)));
    assign stream_last = (7'(idx_reg + 7'd1) >= head_len);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_pop && (count_reg != 4'd0))
                    state_next = S_META;
            end
            S_META:
            begin
                state_next = too_new ? S_IDLE : S_STREAM;
            end
            S_STREAM:
            begin
                if (stream_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath, memory controls and results
    // ---------------------------------------------------------------
    always_comb
    begin
        ws_next      = ws_reg;
        rs_next      = rs_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        overrun_next = overrun_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        cond_next    = cond_reg;
        limit_next   = limit_reg;
        strobe_next  = 1'b0;
        result_next  = '0;
        sample_we    = 1'b0;
        sample_re    = 1'b0;
        meta_we      = 1'b0;
        meta_re      = 1'b0;
        sample_waddr = AW'(AW'(ws_reg) * AW'(FRAME_SAMPLES) + AW'(fill_reg));
        sample_wdata = req.sample;
        sample_raddr = rs_base;
        meta_waddr   = ws_reg;
        meta_raddr   = rs_reg;
        meta_wdata   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_PUSH:
                        begin
                            if (fill_reg < FS7)
                            begin
                                sample_we = 1'b1;
                                fill_next = fill_reg + 7'd1;
                            end
                            else
                                overrun_next = 1'b1;
                            if (req.last_sample)
                            begin
                                // commit: metadata written with the frame
                                meta_we           = 1'b1;
                                meta_wdata.len    = fill_next;
                                meta_wdata.stamp  = req.stamp_in;
                                meta_wdata.header = req.header_in;
                                if (full)
                                begin
                                    rs_next = advance(rs_reg, eff_cap);
                                    result_next.status = ST_DROPPED;
                                end
                                else
                                begin
                                    count_next = count_reg + 4'd1;
                                    result_next.status = ST_STORED;
                                end
                                ws_next      = advance(ws_reg, eff_cap);
                                strobe_next  = 1'b1;
                                result_next.frame_length = fill_next;
                                result_next.truncated    = overrun_next;
                                result_next.last_out     = 1'b1;
                                result_next.occupancy    = count_next;
                                fill_next    = '0;
                                overrun_next = 1'b0;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            ws_next      = '0;
                            rs_next      = '0;
                            count_next   = '0;
                            fill_next    = '0;
                            overrun_next = 1'b0;
                            strobe_next  = 1'b1;
                            result_next.status   = ST_CLEARED;
                            result_next.last_out = 1'b1;
                        end
                        FUNC_POP, FUNC_CPOP:
                        begin
                            if (count_reg == 4'd0)
                            begin
                                strobe_next = 1'b1;
                                result_next.status   = ST_EMPTY;
                                result_next.last_out = 1'b1;
                            end
                            else
                            begin
                                // fetch head metadata and first sample
                                meta_re    = 1'b1;
                                sample_re  = 1'b1;
                                base_next  = rs_base;
                                cond_next  = (req.func == FUNC_CPOP);
                                limit_next = req.frame_limit;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_META:
            begin
                if (too_new)
                begin
                    strobe_next = 1'b1;
                    result_next.status       = ST_TOO_NEW;
                    result_next.frame_length = head_len;
                    result_next.stamp_out    = meta_rd_reg.stamp;
                    result_next.last_out     = 1'b1;
                    result_next.occupancy    = count_reg;
                end
                else
                begin
                    rs_next    = advance(rs_reg, eff_cap);
                    count_next = count_reg - 4'd1;
                    idx_next   = '0;
                end
            end
            S_STREAM:
            begin
                // sample idx is in the read register; fetch the next one
                strobe_next = 1'b1;
                result_next.status       = ST_DELIVERED;
                result_next.sample_out   = sample_rd_reg;
                result_next.frame_length = head_len;
                result_next.stamp_out    = meta_rd_reg.stamp;
                result_next.header_out   = meta_rd_reg.header;
                result_next.last_out     = stream_last;
                result_next.occupancy    = count_reg;
                if (!stream_last)
                begin
                    sample_re    = 1'b1;
                    sample_raddr = AW'(base_reg + AW'(idx_reg + 7'd1));
                    idx_next     = idx_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // memories: one write and one registered read per cycle each
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (sample_we)
            sample_mem[sample_waddr] <= sample_wdata;
        if (sample_re)
            sample_rd_reg <= sample_mem[sample_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        if (meta_re)
            meta_rd_reg <= meta_mem[meta_raddr];
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ws_reg      <= '0;
            rs_reg      <= '0;
            count_reg   <= '0;
            fill_reg    <= '0;
            overrun_reg <= 1'b0;
            idx_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ws_reg      <= ws_next;
            rs_reg      <= rs_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            overrun_reg <= overrun_next;
            idx_reg     <= idx_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        base_reg   <= base_next;
        cond_reg   <= cond_next;
        limit_reg  <= limit_next;
    end

    // configuration register: capacity at byte address 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && pready)
            cap_reg <= pwdata[3:0];
    end

    assign prdata = (paddr == CAP_ADDR) ? {28'd0, cap_reg} : 32'd0;
    assign pready = 1'b1;
    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every streaming cycle produces exactly one result next cycle
    a_stream_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STREAM |=> strobe)
        else $error("stream cycle without result");

    // a pop on an empty queue answers in the next cycle with the empty status
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pop && count_reg == 4'd0
        |=> strobe && result.status == ST_EMPTY && !busy)
        else $error("empty pop not reported");

    // a committing push is answered on the next cycle
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.func == FUNC_PUSH && req.last_sample
        |=> strobe && result.last_out &&
            (result.status == ST_STORED || result.status == ST_DROPPED))
        else $error("commit not reported");

    // the final result of a request is shown only once the block is free
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_out |-> !busy)
        else $error("last result while busy");
`endif

endmodule

[tb/sv/tb_audio_frame_ring_queue_core.sv]
// tb_audio_frame_ring_queue_core: self-checking testbench for the audio frame
// ring queue core. Depends on afrq_pkg and audio_frame_ring_queue_core.
// A built-in predictor tracks the frame store; every result is checked field by field.
module tb_audio_frame_ring_queue_core;
    import afrq_pkg::*;

    localparam int SLOTS          = 8;
    localparam int FRAME_SAMPLES  = 64;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;     // a push without last_sample gives no result
    localparam int TAIL_CYCLES    = 8;
    localparam int STALL_LIMIT    = 3000;  // cycles with no request, result or register write
    localparam int PHASE_ITEMS    = 30;
    localparam int GAP_PERCENT    = 34;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    afrq_in_t    req_bus;
    logic        strobe;
    afrq_out_t   result_bus;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    audio_frame_ring_queue_core #(
        .SLOTS         (SLOTS),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req_bus),
        .strobe  (strobe),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predicted queue state, kept at the block's own widths.
    // ------------------------------------------------------------------
    logic [15:0]        frame_samples [0:SLOTS*FRAME_SAMPLES-1];
    logic [6:0]         frame_lengths [0:SLOTS-1];
    logic signed [63:0] frame_stamps  [0:SLOTS-1];
    logic [63:0]        frame_headers [0:SLOTS-1];
    logic [2:0]         head_slot;
    logic [2:0]         tail_slot;
    logic [3:0]         frames_held;
    logic [6:0]         fill_count;
    logic               fill_overrun;
    logic [3:0]         capacity_reg;

    afrq_out_t results_due [$];   // predicted results, oldest first
    afrq_out_t oldest_due;

    int  error_count   = 0;
    int  requests_sent = 0;
    int  stall_cycles  = 0;
    bit  steady_sender = 1'b0;    // set for a stretch with no sender gaps

    // capacity of 0 behaves as 1, anything above SLOTS as SLOTS
    function automatic int slots_in_use();
        if (capacity_reg == 4'd0)
            return 1;
        if (capacity_reg > SLOTS)
            return SLOTS;
        return int'(capacity_reg);
    endfunction

    function automatic logic [2:0] next_slot(input logic [2:0] slot);
        int nxt;
        nxt = int'(slot) + 1;
        if (nxt >= slots_in_use())
            nxt = 0;
        return nxt[2:0];
    endfunction

    // Apply one accepted request to the predicted state and queue up the
    // results it must produce.
    task automatic predict_queue_step(input afrq_in_t r);
        afrq_out_t          res;
        logic [6:0]         flen;
        logic signed [63:0] bound;
        logic [2:0]         rd;
        int                 base;
        int                 i;
        res = '0;
        res.last_out = 1'b1;
        case (r.func)
            FUNC_PUSH:
            begin
                if (fill_count < FRAME_SAMPLES)
                begin
                    frame_samples[int'(tail_slot)*FRAME_SAMPLES + int'(fill_count)] = r.sample;
                    fill_count = fill_count + 7'd1;
                end
                else
                    fill_overrun = 1'b1;
                if (r.last_sample)
                begin
                    frame_lengths[tail_slot] = fill_count;
                    frame_stamps[tail_slot]  = r.stamp_in;
                    frame_headers[tail_slot] = r.header_in;
                    res.status = ST_STORED;
                    // full queue: the commit pushes out the oldest frame
                    if (int'(frames_held) >= slots_in_use())
                    begin
                        head_slot  = next_slot(head_slot);
                        res.status = ST_DROPPED;
                    end
                    else
                        frames_held = frames_held + 4'd1;
                    tail_slot        = next_slot(tail_slot);
                    res.frame_length = fill_count;
                    res.truncated    = fill_overrun;
                    res.occupancy    = frames_held;
                    fill_count       = '0;
                    fill_overrun     = 1'b0;
                    results_due.push_back(res);
                end
            end
            FUNC_CLEAR:
            begin
                // also throws away a frame still being filled
                head_slot    = '0;
                tail_slot    = '0;
                frames_held  = '0;
                fill_count   = '0;
                fill_overrun = 1'b0;
                res.status   = ST_CLEARED;
                results_due.push_back(res);
            end
            default:
            begin
                if (frames_held == 4'd0)
                begin
                    res.status = ST_EMPTY;
                    results_due.push_back(res);
                end
                else
                begin
                    rd    = head_slot;
                    flen  = frame_lengths[rd];
                    bound = {{32{r.frame_limit[31]}}, r.frame_limit};
                    if (r.func == FUNC_CPOP && frame_stamps[rd] > bound)
                    begin
                        res.status       = ST_TOO_NEW;
                        res.frame_length = flen;
                        res.stamp_out    = frame_stamps[rd];
                        res.occupancy    = frames_held;
                        results_due.push_back(res);
                    end
                    else
                    begin
                        head_slot   = next_slot(rd);
                        frames_held = frames_held - 4'd1;
                        base        = int'(rd) * FRAME_SAMPLES;
                        for (i = 0; i < int'(flen); i++)
                        begin
                            res.status       = ST_DELIVERED;
                            res.sample_out   = frame_samples[base + i];
                            res.frame_length = flen;
                            res.stamp_out    = frame_stamps[rd];
                            res.header_out   = frame_headers[rd];
                            res.last_out     = (i == int'(flen) - 1);
                            res.truncated    = 1'b0;
                            res.occupancy    = frames_held;
                            results_due.push_back(res);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ERROR %s expected %0h actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic compare_result(input afrq_out_t want, input afrq_out_t got);
        report_field("status",       64'(want.status),       64'(got.status));
        report_field("sample_out",   64'(want.sample_out),   64'(got.sample_out));
        report_field("frame_length", 64'(want.frame_length), 64'(got.frame_length));
        report_field("stamp_out",    want.stamp_out,         got.stamp_out);
        report_field("header_out",   want.header_out,        got.header_out);
        report_field("last_out",     64'(want.last_out),     64'(got.last_out));
        report_field("truncated",    64'(want.truncated),    64'(got.truncated));
        report_field("occupancy",    64'(want.occupancy),    64'(got.occupancy));
    endtask

    // ------------------------------------------------------------------
    // Monitor: one process, so register writes, request acceptance and
    // result checks at the same edge always happen in this order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_cycles = stall_cycles + 1;
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
            begin
                capacity_reg = pwdata[3:0];
                stall_cycles = 0;
            end
            if (start && !busy)
            begin
                predict_queue_step(req_bus);
                stall_cycles = 0;
            end
            if (strobe)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, actual status %0d",
                             $time, result_bus.status);
                    error_count++;
                end
                else
                begin
                    stall_cycles = 0;
                    oldest_due = results_due.pop_front();
                    compare_result(oldest_due, result_bus);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("audio_frame_ring_queue_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one request; returns just after the edge that accepted it.
    // start stays high, so back-to-back requests need no extra cycle.
    task automatic issue_request(input afrq_in_t item);
        @(negedge clk);
        if (!steady_sender)
            while ($urandom_range(99) < GAP_PERCENT)
            begin
                start = 1'b0;
                @(negedge clk);
            end
        start   = 1'b1;
        req_bus = item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
    endtask

    // Hold off the sender until every predicted result has arrived, then let
    // a trailing push settle.
    task automatic wait_results_done();
        @(negedge clk);
        start = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic afrq_in_t random_request(input logic [1:0] func);
        afrq_in_t item;
        item.func        = func;
        item.sample      = 16'($urandom);
        item.last_sample = 1'($urandom_range(1));
        item.stamp_in    = {$urandom, $urandom};
        item.header_in   = {$urandom, $urandom};
        item.frame_limit = $urandom;
        return item;
    endfunction

    // stamps cluster around the small limits so both compare outcomes occur
    function automatic logic signed [63:0] pick_stamp();
        logic signed [63:0] v;
        logic [31:0]        w;
        int                 d;
        w = $urandom;
        d = $urandom_range(40);
        d = d - 20;
        case ($urandom_range(2))
            0:       v = 64'(d);
            1:       v = {{32{w[31]}}, w};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic afrq_in_t cond_pop_request();
        afrq_in_t item;
        int       d;
        item = random_request(FUNC_CPOP);
        d    = $urandom_range(40);
        if ($urandom_range(1))
            item.frame_limit = d - 20;
        return item;
    endfunction

    // One frame of n random samples; pops may slip in between samples.
    task automatic push_frame(input int n, input int interleave_pct);
        afrq_in_t item;
        int       i;
        for (i = 0; i < n; i++)
        begin
            item             = random_request(FUNC_PUSH);
            item.last_sample = (i == n - 1);
            item.stamp_in    = pick_stamp();
            issue_request(item);
            if (i < n - 1 && $urandom_range(99) < interleave_pct)
                issue_request($urandom_range(1) ? random_request(FUNC_POP)
                                                : cond_pop_request());
        end
    endtask

    // APB write of the capacity register, then a read back of it.
    task automatic write_capacity(input logic [3:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = CAP_ADDR;
        pwdata  = {28'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== {28'd0, value})
        begin
            $display("%0t ERROR capacity read expected %0h actual %0h",
                     $time, {28'd0, value}, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // New capacity from an empty queue, so no pop can reach an unwritten slot.
    task automatic set_capacity_idle(input logic [3:0] value);
        wait_results_done();
        issue_request(random_request(FUNC_CLEAR));
        wait_results_done();
        write_capacity(value);
    endtask

    task automatic run_traffic_phase(input int quota, input int long_len);
        int phase_start;
        int pick;
        int n;
        phase_start = requests_sent;
        if (long_len > 0)
            push_frame(long_len, 0);
        while (requests_sent - phase_start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                n = ($urandom_range(99) < 88) ? $urandom_range(1, 6) : $urandom_range(7, 20);
                push_frame(n, 10);
            end
            else if (pick < 68)
                issue_request(random_request(FUNC_POP));
            else if (pick < 83)
                issue_request(cond_pop_request());
            else if (pick < 87)
                issue_request(random_request(FUNC_CLEAR));
            else if (pick < 96)
                issue_request(random_request(2'($urandom_range(3))));  // stray request
            else
                wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // pop, conditional pop and clear with nothing stored
    task automatic test_empty_queue();
        issue_request(random_request(FUNC_POP));
        issue_request(cond_pop_request());
        issue_request(random_request(FUNC_CLEAR));
    endtask

    // sample, stamp, header and limit extremes; the limit is sign-extended
    task automatic test_sample_stamp_extremes();
        afrq_in_t item;
        item = random_request(FUNC_PUSH);
        item.sample      = 16'sh8000;
        item.last_sample = 1'b0;
        issue_request(item);
        item.sample      = 16'sh7fff;
        item.last_sample = 1'b1;
        item.stamp_in    = 64'sh7fff_ffff_ffff_ffff;
        item.header_in   = '1;
        issue_request(item);
        item.sample      = '0;
        item.stamp_in    = 64'sh8000_0000_0000_0000;
        item.header_in   = '0;
        issue_request(item);
        issue_request(random_request(FUNC_POP));
        // most negative stamp against most negative limit: delivered
        item = random_request(FUNC_CPOP);
        item.frame_limit = 32'sh8000_0000;
        issue_request(item);
        item = random_request(FUNC_PUSH);
        item.last_sample = 1'b1;
        item.stamp_in    = 64'sh0000_0000_8000_0000;
        issue_request(item);
        // one above the largest limit: too new
        item = random_request(FUNC_CPOP);
        item.frame_limit = 32'sh7fff_ffff;
        issue_request(item);
        item = random_request(FUNC_PUSH);
        item.last_sample = 1'b1;
        item.stamp_in    = 64'shffff_ffff_8000_0000;
        issue_request(item);
        issue_request(random_request(FUNC_POP));
        // equal only if the limit is sign-extended
        item = random_request(FUNC_CPOP);
        item.frame_limit = 32'sh8000_0000;
        issue_request(item);
    endtask

    // clear discards the frame being filled as well as the stored ones
    task automatic test_clear_drops_partial_frame();
        afrq_in_t item;
        push_frame(1, 0);
        item = random_request(FUNC_PUSH);
        item.last_sample = 1'b0;
        issue_request(item);
        issue_request(item);
        issue_request(random_request(FUNC_CLEAR));
        push_frame(1, 0);
        issue_request(random_request(FUNC_POP));
    endtask

    // capacity 0 acts as one slot: the frame in progress overwrites the
    // oldest one in place, a pop meanwhile sees the new sample
    task automatic test_full_queue_overwrite();
        afrq_in_t item;
        set_capacity_idle(4'd0);
        push_frame(1, 0);
        item = random_request(FUNC_PUSH);
        item.last_sample = 1'b0;
        issue_request(item);
        issue_request(random_request(FUNC_POP));
        item = random_request(FUNC_PUSH);
        item.last_sample = 1'b1;
        issue_request(item);
        push_frame(1, 0);
        issue_request(random_request(FUNC_POP));
    endtask

    // shrink the capacity while all slots hold written frames
    task automatic test_resize_while_held();
        int i;
        set_capacity_idle(4'd15);
        for (i = 0; i < SLOTS + 1; i++)
            push_frame(1, 0);
        wait_results_done();
        write_capacity(4'd3);
        push_frame(2, 0);
        issue_request(random_request(FUNC_POP));
        issue_request(cond_pop_request());
        push_frame(3, 0);
        issue_request(random_request(FUNC_POP));
        issue_request(random_request(FUNC_POP));
    endtask

    task automatic test_random_traffic();
        set_capacity_idle(4'd15);
        run_traffic_phase(PHASE_ITEMS, FRAME_SAMPLES);
        set_capacity_idle(4'd2);
        run_traffic_phase(PHASE_ITEMS, 0);
        set_capacity_idle(4'd0);
        run_traffic_phase(PHASE_ITEMS, 0);
        set_capacity_idle(4'd7);
        steady_sender = 1'b1;
        run_traffic_phase(PHASE_ITEMS, 0);
        steady_sender = 1'b0;
        set_capacity_idle(4'd1);
        run_traffic_phase(PHASE_ITEMS, $urandom_range(FRAME_SAMPLES + 1, FRAME_SAMPLES + 4));
        set_capacity_idle(4'd8);
        run_traffic_phase(PHASE_ITEMS, 0);
        set_capacity_idle(4'd5);
        run_traffic_phase(PHASE_ITEMS, 0);
        set_capacity_idle(4'd3);
        run_traffic_phase(PHASE_ITEMS, 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_bus      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = CAP_ADDR;
        pwdata       = '0;
        head_slot    = '0;
        tail_slot    = '0;
        frames_held  = '0;
        fill_count   = '0;
        fill_overrun = 1'b0;
        capacity_reg = CAP_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_sample_stamp_extremes();
        test_clear_drops_partial_frame();
        test_full_queue_overwrite();
        test_resize_while_held();
        test_random_traffic();

        // drain, then watch a few more cycles for stray results
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("audio_frame_ring_queue_core verification clean");
        else
            $display("audio_frame_ring_queue_core verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/afrq_pkg.sv
rtl/core/audio_frame_ring_queue_core.sv
tb/sv/tb_audio_frame_ring_queue_core.sv
